/* src/upd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared types, character constants and the hex digit lookup.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_end;
    } out_item_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] b);
        hex_t h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            h.value = 4'(b - 8'h41 + 8'd10);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            h.value = 4'(b - 8'h61 + 8'd10);
        end
        else
        begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

/* src/upd_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder input stage
// Registers each accepted request and holds it until the decode stage takes it.
// ----------------------------------------------------------------------------
module upd_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire upd_pkg::in_item_t in_item,
    output logic                  stage_valid,
    input  wire logic             stage_ready,
    output upd_pkg::in_item_t     stage_item
);
    import upd_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    assign in_ready    = !valid_reg || stage_ready;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule
`default_nettype wire

/* src/upd_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder escape stage
// Escape state machine and result register: one request in, one result out.
// ----------------------------------------------------------------------------
module upd_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire upd_pkg::in_item_t  item,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output upd_pkg::out_item_t     res
);
    import upd_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] held_reg;
    logic [3:0] held_next;
    logic       res_valid_reg;
    out_item_t  res_reg;
    out_item_t  res_next;
    hex_t       hex;
    logic       take_plain;
    logic       fire;

    assign item_ready = !res_valid_reg || res_ready;
    assign fire       = item_valid && item_ready;
    assign hex        = hex_value(item.in_byte);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        phase_next          = PH_PLAIN;
        held_next           = held_reg;
        take_plain          = 1'b0;
        res_next.out_byte   = 8'd0;
        res_next.byte_valid = 1'b0;
        res_next.string_end = item.in_last;

        unique case (phase_reg)
            PH_PCT:
            begin
                if (hex.is_hex && !item.in_last)
                begin
                    held_next  = hex.value;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    take_plain = 1'b1;
                end
            end
            PH_DIGIT:
            begin
                res_next.byte_valid = 1'b1;
                res_next.out_byte   = hex.is_hex ? {held_reg, hex.value} : {4'd0, held_reg};
                held_next           = 4'd0;
            end
            default:
            begin
                take_plain = 1'b1;
            end
        endcase

        if (take_plain)
        begin
            if (item.in_byte == CH_PERCENT)
            begin
                phase_next = item.in_last ? PH_PLAIN : PH_PCT;
            end
            else if (item.in_byte == CH_PLUS)
            begin
                res_next.byte_valid = 1'b1;
                res_next.out_byte   = CH_SPACE;
            end
            else
            begin
                res_next.byte_valid = 1'b1;
                res_next.out_byte   = item.in_byte;
            end
        end

        if (item.in_last)
        begin
            phase_next = PH_PLAIN;
            held_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PLAIN;
            held_reg      <= 4'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
            end
            if (item_ready)
            begin
                res_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

/* src/url_percent_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder for percent-encoded strings, one byte per request.
//
// The slave channel takes one encoded byte per request, with tlast on the
// final byte of each string. The master channel gives exactly one result per
// input request: tdata holds the decoded byte (zero when none), tuser says
// whether a byte is carried, and tlast repeats the input's end-of-string mark.
// A '+' becomes a space; a '%', a hex digit and one more byte form an escape;
// the '%' and first digit of an escape give results with no byte.
// The block is a two-register pipeline: an accepted request is held in the
// input register, and the escape stage then registers its result, which is
// offered on the master channel. One request is taken every cycle while the
// receiver keeps up. When the receiver stalls, each register holds its request
// and tready falls only once both registers are full.
// Reset empties both registers and returns the escape state to plain text.
// ----------------------------------------------------------------------------
module url_percent_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // in_last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tuser,   // [0] byte_valid
    output logic            m_axis_tlast    // string_end
);
    import upd_pkg::*;

    in_item_t  in_item;
    in_item_t  stage_item;
    logic      stage_valid;
    logic      stage_ready;
    out_item_t res;

    assign in_item.in_byte = s_axis_tdata;
    assign in_item.in_last = s_axis_tlast;

    upd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_item     (in_item),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage_item  (stage_item)
    );

    upd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (stage_valid),
        .item_ready (stage_ready),
        .item       (stage_item),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tdata = res.out_byte;
    assign m_axis_tuser = res.byte_valid;
    assign m_axis_tlast = res.string_end;

endmodule
`default_nettype wire
